// ===== rtl/tvcm_pkg.sv =====
package tvcm_pkg;

    localparam int IN_LANES_DEF     = 4;
    localparam int OUT_CHANNELS_DEF = 8;

    localparam int FIELD_LANES = 4;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_SHIFT  = 14;
    localparam int RND_W       = ACC_W - FRAC_SHIFT;
    localparam int CH_W        = 3;
    localparam int MAX_TARGETS = 1 << CH_W;

    localparam int IN_CH_W    = 3;
    localparam int OUT_CH_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_CHANNELS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CHANNELS = 1'd1;

    localparam logic [IN_CH_W-1:0]  IN_CH_RESET  = 3'd2;
    localparam logic [OUT_CH_W-1:0] OUT_CH_RESET = 4'd2;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 36'sd8192;
    localparam logic signed [RND_W-1:0] RND_MAX    = 22'sd32767;
    localparam logic signed [RND_W-1:0] RND_MIN    = -22'sd32768;

    typedef struct packed {
        logic load1;
        logic load2;
        logic take;
        logic present;
    } t_lane_ctl;

endpackage

// ===== rtl/tvcm_lane.sv =====
module tvcm_lane #(
    parameter int LANE      = 0,
    parameter int STORE_ROWS = 8,
    parameter int ROW_W     = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tvcm_pkg::t_lane_ctl                    i_ctl,
    input  logic [tvcm_pkg::IN_CH_W-1:0]           i_lanes,
    input  logic [ROW_W-1:0]                       i_row,
    input  logic signed [tvcm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic signed [tvcm_pkg::COEF_W-1:0]     i_coef,
    output logic signed [tvcm_pkg::PROD_W-1:0]     o_prod
);

    localparam logic [tvcm_pkg::IN_CH_W-1:0] IN_CH_W_LANE = tvcm_pkg::IN_CH_W'(LANE);

    logic signed [tvcm_pkg::COEF_W-1:0]   r_mem [STORE_ROWS];
    logic [STORE_ROWS-1:0]                r_vld;
    logic signed [tvcm_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [tvcm_pkg::COEF_W-1:0]   r_coef;
    logic signed [tvcm_pkg::PROD_W-1:0]   r_prod;

    logic                                 active;
    logic                                 wr;
    logic signed [tvcm_pkg::COEF_W-1:0]   held;
    logic signed [tvcm_pkg::SAMPLE_W-1:0] n_sample;
    logic signed [tvcm_pkg::COEF_W-1:0]   n_coef;

    assign active   = IN_CH_W_LANE < i_lanes;
    assign wr       = i_ctl.take && i_ctl.present && active;
    assign held     = r_vld[i_row] ? r_mem[i_row] : '0;
    assign n_sample = active ? i_sample : '0;
    assign n_coef   = i_ctl.present ? i_coef : held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr) begin
            r_vld[i_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[i_row] <= i_coef;
        end
        if (i_ctl.load1) begin
            r_sample <= n_sample;
            r_coef   <= n_coef;
        end
        if (i_ctl.load2) begin
            r_prod <= r_sample * r_coef;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/tvcm_merge.sv =====
module tvcm_merge #(
    parameter int LANES = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  logic [LANES-1:0][tvcm_pkg::PROD_W-1:0]     i_prods,
    input  logic [tvcm_pkg::CH_W-1:0]                  i_channel,
    output logic                                       o_ready,
    input  logic                                       i_stall,
    output logic                                       o_valid,
    output logic signed [tvcm_pkg::SAMPLE_W-1:0]       o_mixed_sample,
    output logic [tvcm_pkg::CH_W-1:0]                  o_mixed_channel,
    output logic                                       o_clipped
);

    logic                                 r_valid;
    logic signed [tvcm_pkg::SAMPLE_W-1:0] r_sample;
    logic [tvcm_pkg::CH_W-1:0]            r_channel;
    logic                                 r_clipped;

    logic signed [tvcm_pkg::ACC_W-1:0]    acc;
    logic signed [tvcm_pkg::ACC_W-1:0]    biased;
    logic signed [tvcm_pkg::RND_W-1:0]    rnd;
    logic signed [tvcm_pkg::SAMPLE_W-1:0] n_sample;
    logic                                 n_clipped;

    always_comb begin
        acc = '0;
        for (int l = 0; l < LANES; l++) begin
            acc = acc + tvcm_pkg::ACC_W'(signed'(i_prods[l]));
        end
    end

    assign biased = acc + tvcm_pkg::ROUND_BIAS;
    assign rnd    = biased[tvcm_pkg::ACC_W-1:tvcm_pkg::FRAC_SHIFT];

    always_comb begin
        priority if (rnd > tvcm_pkg::RND_MAX) begin
            n_sample  = tvcm_pkg::RND_MAX[tvcm_pkg::SAMPLE_W-1:0];
            n_clipped = 1'b1;
        end else if (rnd < tvcm_pkg::RND_MIN) begin
            n_sample  = tvcm_pkg::RND_MIN[tvcm_pkg::SAMPLE_W-1:0];
            n_clipped = 1'b1;
        end else begin
            n_sample  = rnd[tvcm_pkg::SAMPLE_W-1:0];
            n_clipped = 1'b0;
        end
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample  <= n_sample;
            r_channel <= i_channel;
            r_clipped <= n_clipped;
        end
    end

    assign o_valid         = r_valid;
    assign o_mixed_sample  = r_sample;
    assign o_mixed_channel = r_channel;
    assign o_clipped       = r_clipped;

endmodule

// ===== rtl/time_varying_channel_mixer.sv =====
// channel   direction  handshake            beat
// input     in         i_valid / o_stall    i_sample_0..3, i_coef_0..3, i_target_channel,
//                                           i_coef_present
// output    out        o_valid / i_stall    o_mixed_sample, o_mixed_channel, o_clipped
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
// One beat per cycle while o_stall is low; a result passes through the registered stages
// (lane select/store, multiply, sum-round-saturate into the output register).
// Reset is synchronous: channel counts return to 2 and 2, held coefficients read as zero.
// o_stall rises only when all three stages hold beats and i_stall holds the output.
// A beat whose target is outside the layout is taken and dropped.
module time_varying_channel_mixer #(
    parameter int IN_LANES     = tvcm_pkg::IN_LANES_DEF,
    parameter int OUT_CHANNELS = tvcm_pkg::OUT_CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tvcm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tvcm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [tvcm_pkg::SAMPLE_W-1:0]   i_sample_0,
    input  logic signed [tvcm_pkg::SAMPLE_W-1:0]   i_sample_1,
    input  logic signed [tvcm_pkg::SAMPLE_W-1:0]   i_sample_2,
    input  logic signed [tvcm_pkg::SAMPLE_W-1:0]   i_sample_3,
    input  logic signed [tvcm_pkg::COEF_W-1:0]     i_coef_0,
    input  logic signed [tvcm_pkg::COEF_W-1:0]     i_coef_1,
    input  logic signed [tvcm_pkg::COEF_W-1:0]     i_coef_2,
    input  logic signed [tvcm_pkg::COEF_W-1:0]     i_coef_3,
    input  logic [tvcm_pkg::CH_W-1:0]              i_target_channel,
    input  logic                                   i_coef_present,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [tvcm_pkg::SAMPLE_W-1:0]   o_mixed_sample,
    output logic [tvcm_pkg::CH_W-1:0]              o_mixed_channel,
    output logic                                   o_clipped
);

    localparam int LANES_USED = (IN_LANES < tvcm_pkg::FIELD_LANES) ?
                                IN_LANES : tvcm_pkg::FIELD_LANES;
    localparam int STORE_ROWS = (OUT_CHANNELS < tvcm_pkg::MAX_TARGETS) ?
                                OUT_CHANNELS : tvcm_pkg::MAX_TARGETS;
    localparam int ROW_W      = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int OUT_N_W    = 6;
    localparam logic [OUT_N_W-1:0]            OUT_MAX   = OUT_N_W'(OUT_CHANNELS);
    localparam logic [tvcm_pkg::IN_CH_W-1:0]  LANES_MAX = tvcm_pkg::IN_CH_W'(LANES_USED);

    logic [tvcm_pkg::IN_CH_W-1:0]  r_in_ch;
    logic [tvcm_pkg::OUT_CH_W-1:0] r_out_ch;
    logic                          r_v1;
    logic                          r_v2;
    logic [tvcm_pkg::CH_W-1:0]     r_ch1;
    logic [tvcm_pkg::CH_W-1:0]     r_ch2;

    logic [tvcm_pkg::IN_CH_W-1:0]  lanes_eff;
    logic [OUT_N_W-1:0]            out_n;
    logic [OUT_N_W-1:0]            out_eff;
    logic                          hit;
    logic                          accept;
    logic                          s1_ready;
    logic                          s2_ready;
    logic                          s3_ready;
    tvcm_pkg::t_lane_ctl           lane_ctl;
    logic [ROW_W-1:0]              row;

    logic signed [tvcm_pkg::SAMPLE_W-1:0] samples [tvcm_pkg::FIELD_LANES];
    logic signed [tvcm_pkg::COEF_W-1:0]   coefs   [tvcm_pkg::FIELD_LANES];
    logic [LANES_USED-1:0][tvcm_pkg::PROD_W-1:0] prods;

    assign samples[0] = i_sample_0;
    assign samples[1] = i_sample_1;
    assign samples[2] = i_sample_2;
    assign samples[3] = i_sample_3;
    assign coefs[0]   = i_coef_0;
    assign coefs[1]   = i_coef_1;
    assign coefs[2]   = i_coef_2;
    assign coefs[3]   = i_coef_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= tvcm_pkg::IN_CH_RESET;
            r_out_ch <= tvcm_pkg::OUT_CH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tvcm_pkg::REG_INPUT_CHANNELS: begin
                    r_in_ch <= i_cfg_data[tvcm_pkg::IN_CH_W-1:0];
                end
                tvcm_pkg::REG_OUTPUT_CHANNELS: begin
                    r_out_ch <= i_cfg_data[tvcm_pkg::OUT_CH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if (r_in_ch == '0) begin
            lanes_eff = tvcm_pkg::IN_CH_W'(1);
        end else if (r_in_ch > LANES_MAX) begin
            lanes_eff = LANES_MAX;
        end else begin
            lanes_eff = r_in_ch;
        end
    end

    assign out_n = OUT_N_W'(r_out_ch);

    always_comb begin
        priority if (out_n == '0) begin
            out_eff = OUT_N_W'(1);
        end else if (out_n > OUT_MAX) begin
            out_eff = OUT_MAX;
        end else begin
            out_eff = out_n;
        end
    end

    assign hit      = OUT_N_W'(i_target_channel) < out_eff;
    assign s2_ready = !r_v2 || s3_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_stall  = !s1_ready;
    assign accept   = i_valid && s1_ready;
    assign row      = i_target_channel[ROW_W-1:0];

    assign lane_ctl.load1   = s1_ready;
    assign lane_ctl.load2   = s2_ready;
    assign lane_ctl.take    = accept && hit;
    assign lane_ctl.present = i_coef_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= accept && hit;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_ch1 <= i_target_channel;
        end
        if (s2_ready) begin
            r_ch2 <= r_ch1;
        end
    end

    for (genvar l = 0; l < LANES_USED; l++) begin : g_lane
        tvcm_lane #(
            .LANE       (l),
            .STORE_ROWS (STORE_ROWS),
            .ROW_W      (ROW_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_lanes  (lanes_eff),
            .i_row    (row),
            .i_sample (samples[l]),
            .i_coef   (coefs[l]),
            .o_prod   (prods[l])
        );
    end

    tvcm_merge #(
        .LANES (LANES_USED)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_v2),
        .i_prods         (prods),
        .i_channel       (r_ch2),
        .o_ready         (s3_ready),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_mixed_sample  (o_mixed_sample),
        .o_mixed_channel (o_mixed_channel),
        .o_clipped       (o_clipped)
    );

    a_drop_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !hit) |=> !r_v1)
        else $error("beat outside layout entered pipeline");

    a_hold_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !s3_ready) |=> (r_v2 && $stable(r_ch2)))
        else $error("stage 2 beat lost under stall");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && o_valid))
        else $error("stall with free pipeline stage");

    a_out_in_layout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (OUT_N_W'(o_mixed_channel) < out_eff))
        else $error("result for channel outside layout");

endmodule
